[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the rtl checkers
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error(msg);

// condition must never be seen outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  `ASSERT_PROP(label, clk, rst_n, !(cond), msg)

`endif

[hw/rtl/riprel_pkg.sv]
// ----------------------------------------------------------------------------
// riprel_pkg
// types and constants shared by the rip-relative reference scanner
// ----------------------------------------------------------------------------
package riprel_pkg;

  localparam int unsigned AddrWidth   = 64;
  localparam int unsigned CountWidth  = 32;
  localparam int unsigned ImmWidth    = 3;
  localparam int unsigned WindowBytes = 5;

  localparam logic [7:0] ModrmMask   = 8'hC7;
  localparam logic [7:0] ModrmRiprel = 8'h05;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_SECTION_ADDRESS     = 2'd0,
    REG_SECTION_FILE_OFFSET = 2'd1,
    REG_TARGET_ADDRESS      = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0] code_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [AddrWidth-1:0]  ref_address;
    logic [AddrWidth-1:0]  ref_file_offset;
    logic [ImmWidth-1:0]   imm_length;
    logic [CountWidth-1:0] match_count;
  } out_item_t;

  // verdict of the displacement check
  typedef struct packed {
    logic                hit;
    logic [ImmWidth-1:0] imm_length;
  } match_t;

endpackage

[hw/rtl/riprel_match.sv]
// ----------------------------------------------------------------------------
// riprel_match
// resolves a disp32 against the target and tests the immediate lengths
// ----------------------------------------------------------------------------
module riprel_match (
  input  logic                            cand_i,
  input  logic [riprel_pkg::AddrWidth-1:0] target_i,
  input  logic [riprel_pkg::AddrWidth-1:0] at_i,
  input  logic [31:0]                     disp_i,
  output riprel_pkg::match_t              match_o
);
  import riprel_pkg::*;

  logic [AddrWidth-1:0] disp_ext;
  logic [AddrWidth-1:0] diff;
  logic                 len_ok;

  // target - (at + 4 + disp) must be one of the immediate lengths
  assign disp_ext = {{(AddrWidth-32){disp_i[31]}}, disp_i};
  assign diff     = target_i - at_i - disp_ext - AddrWidth'(4);

  always_comb begin
    case (diff[2:0])
      3'd0, 3'd1, 3'd2, 3'd4: len_ok = 1'b1;
      default:                len_ok = 1'b0;
    endcase
  end

  assign match_o.hit        = cand_i && (diff[AddrWidth-1:3] == '0) && len_ok;
  assign match_o.imm_length = diff[ImmWidth-1:0];

endmodule

[hw/rtl/rip_relative_reference_scanner.sv]
// ----------------------------------------------------------------------------
// rip_relative_reference_scanner
// scans a code byte stream for rip-relative operands that reach a target
// ----------------------------------------------------------------------------
// usage:
//   input channel (in_valid_i / in_ready_o) takes one section byte per
//   transfer, last_byte marking the end of the section. output channel
//   (out_valid_o / out_ready_i) gives one transfer per match found.
//   the user must make configuration writes (cfg_we_i, cfg_idx_i, cfg_wdata_i)
//   only while the block is idle, which it does not enforce; index 3 is ignored.
// path: the byte that completes the disp32 lands in the input register at
//   its transfer edge, then moves on into the result register, which drives
//   out_valid_o, once that register has room for it.
// throughput: one byte per cycle while the receiver keeps out_ready_i high.
//   the check is one pass of 64-bit adds and compares in riprel_match.
// stall: a held result blocks the input register only when the next byte
//   must advance; in_ready_o stays high while the input register is free.
// reset: window, position and match count clear; the three address
//   registers go to zero. the same clearing of the section state follows
//   every byte marked last_byte.
// ----------------------------------------------------------------------------
module rip_relative_reference_scanner #(
  parameter int unsigned POSITION_BITS = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // byte input
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  riprel_pkg::in_item_t             in_item_i,
  // match output
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output riprel_pkg::out_item_t            out_item_o,
  // configuration writes
  input  logic                             cfg_we_i,
  input  logic [1:0]                       cfg_idx_i,
  input  logic [riprel_pkg::AddrWidth-1:0] cfg_wdata_i
);
  import riprel_pkg::*;

  // configuration registers
  logic [AddrWidth-1:0] sec_addr_q, sec_offs_q, target_q;

  // section state: last four bytes, saturating position, match count
  logic [7:0]               win_q [4];
  logic [7:0]               win_d [4];
  logic [POSITION_BITS-1:0] pos_q, pos_d;
  logic [CountWidth-1:0]    count_q, count_d;

  // input register stage
  logic                 s1_valid_q, s1_valid_d;
  logic                 s1_cand_q;
  logic [31:0]          s1_disp_q;
  logic [AddrWidth-1:0] s1_at_q;
  logic [AddrWidth-1:0] s1_offs_q;
  logic                 s1_last_q;

  // result register
  logic      out_valid_q, out_valid_d;
  out_item_t out_item_q;

  logic                     in_fire;
  logic                     out_space;
  logic                     s1_go;
  logic [POSITION_BITS-1:0] cand_pos;
  logic [AddrWidth-1:0]     cand_pos_ext;
  logic                     cand;
  match_t                   match;
  logic [CountWidth-1:0]    count_inc;

  // handshakes: the input register drains whenever the result register has room
  assign out_space  = !out_valid_q || out_ready_i;
  assign s1_go      = s1_valid_q && out_space;
  assign in_ready_o = !s1_valid_q || out_space;
  assign in_fire    = in_valid_i && in_ready_o;

  // the candidate modrm sits at position pos_q - 4 (oldest byte of the window)
  assign cand_pos     = pos_q - POSITION_BITS'(WindowBytes - 1);
  assign cand_pos_ext = AddrWidth'(cand_pos);
  assign cand         = (pos_q >= POSITION_BITS'(WindowBytes - 1)) &&
                        ((win_q[0] & ModrmMask) == ModrmRiprel);

  // window shift and position count, cleared after the last byte
  always_comb begin
    win_d[0] = win_q[1];
    win_d[1] = win_q[2];
    win_d[2] = win_q[3];
    win_d[3] = in_item_i.code_byte;
    pos_d    = (pos_q != '1) ? pos_q + POSITION_BITS'(1) : pos_q;
    if (in_item_i.last_byte) begin
      win_d[0] = '0;
      win_d[1] = '0;
      win_d[2] = '0;
      win_d[3] = '0;
      pos_d    = '0;
    end
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_fire) begin
      s1_valid_d = 1'b1;
    end else if (s1_go) begin
      s1_valid_d = 1'b0;
    end
  end

  riprel_match u_match (
    .cand_i   (s1_cand_q),
    .target_i (target_q),
    .at_i     (s1_at_q),
    .disp_i   (s1_disp_q),
    .match_o  (match)
  );

  // match count saturates; it restarts after the section's last byte
  assign count_inc = (count_q != '1) ? count_q + CountWidth'(1) : count_q;

  always_comb begin
    count_d = count_q;
    if (s1_go) begin
      if (s1_last_q) begin
        count_d = '0;
      end else if (match.hit) begin
        count_d = count_inc;
      end
    end
  end

  assign out_valid_d = out_space ? (s1_valid_q && match.hit) : out_valid_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sec_addr_q <= '0;
      sec_offs_q <= '0;
      target_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_SECTION_ADDRESS:     sec_addr_q <= cfg_wdata_i;
        REG_SECTION_FILE_OFFSET: sec_offs_q <= cfg_wdata_i;
        REG_TARGET_ADDRESS:      target_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q[0]    <= '0;
      win_q[1]    <= '0;
      win_q[2]    <= '0;
      win_q[3]    <= '0;
      pos_q       <= '0;
      count_q     <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        win_q <= win_d;
        pos_q <= pos_d;
      end
      count_q     <= count_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // input register payload: candidate flag, disp32, field addresses and last flag
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_cand_q <= cand;
      s1_disp_q <= {in_item_i.code_byte, win_q[3], win_q[2], win_q[1]};
      s1_at_q   <= sec_addr_q + cand_pos_ext + AddrWidth'(1);
      s1_offs_q <= sec_offs_q + cand_pos_ext + AddrWidth'(1);
      s1_last_q <= in_item_i.last_byte;
    end
  end

  // result register payload
  always_ff @(posedge clk_i) begin
    if (s1_go && match.hit) begin
      out_item_q.ref_address     <= s1_at_q;
      out_item_q.ref_file_offset <= s1_offs_q;
      out_item_q.imm_length      <= match.imm_length;
      out_item_q.match_count     <= count_inc;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

[hw/rtl/riprel_checker.sv]
// ----------------------------------------------------------------------------
// riprel_checker
// port-level assertions for the rip-relative reference scanner
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module riprel_checker (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  out_valid_i,
  input logic                  out_ready_i,
  input riprel_pkg::out_item_t out_item_i
);
  import riprel_pkg::*;

  // a stalled result stays put
  `ASSERT_PROP(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_item_i), "stalled result changed")

  // only the four immediate lengths can be reported
  `ASSERT_PROP(a_imm_legal, clk_i, rst_ni, out_valid_i |-> (out_item_i.imm_length == 3'd0 || out_item_i.imm_length == 3'd1 || out_item_i.imm_length == 3'd2 || out_item_i.imm_length == 3'd4), "illegal immediate length")

  // a reported match always counts itself
  `ASSERT_NEVER(a_count_nonzero, clk_i, rst_ni, out_valid_i && (out_item_i.match_count == '0), "match count of zero")

endmodule

bind rip_relative_reference_scanner riprel_checker u_riprel_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_i  (out_item_o)
);

[verif/tb_rip_relative_reference_scanner.sv]
// ----------------------------------------------------------------------------
// tb_rip_relative_reference_scanner
// self-checking bench: streams code sections into the scanner, plants
// rip-relative operands that resolve to the target under random settings,
// predicts every match in a scoreboard and checks the output in order
// ----------------------------------------------------------------------------
module tb_rip_relative_reference_scanner;
  import riprel_pkg::*;

  localparam int unsigned PositionBits = 32;
  localparam int unsigned QuietLimit   = 1000;  // cycles without any transfer
  localparam int unsigned DrainCycles  = 8;     // covers the input and result registers
  localparam int unsigned TailCycles   = 16;
  localparam int unsigned RandomItems  = 500;

  // the only index the block must ignore
  localparam logic [1:0] RegUnused = 2'd3;

  // immediate lengths tried at each candidate, in priority order
  localparam logic [3:0][ImmWidth-1:0] ImmLengths = {3'd4, 3'd2, 3'd1, 3'd0};

  // --------------------------------------------------------------------------
  // scoreboard: own copy of registers and section state, queue of the
  // matches the block still owes us
  // --------------------------------------------------------------------------
  class match_ledger;
    logic [AddrWidth-1:0]    sect_addr;
    logic [AddrWidth-1:0]    sect_offset;
    logic [AddrWidth-1:0]    target_addr;
    logic [7:0]              window [4];
    logic [PositionBits-1:0] position;
    logic [CountWidth-1:0]   match_total;
    out_item_t               pending [$];
    int unsigned             bytes_seen, sections_seen, results_seen;
    int unsigned             expected_total, errors;
    int unsigned             len_hits [4];

    function new();
      sect_addr      = '0;
      sect_offset    = '0;
      target_addr    = '0;
      bytes_seen     = 0;
      sections_seen  = 0;
      results_seen   = 0;
      expected_total = 0;
      errors         = 0;
      foreach (len_hits[k]) len_hits[k] = 0;
      clear_section();
    endfunction

    function void clear_section();
      foreach (window[k]) window[k] = '0;
      position    = '0;
      match_total = '0;
    endfunction

    function void set_register(logic [1:0] idx, logic [AddrWidth-1:0] data);
      case (cfg_reg_e'(idx))
        REG_SECTION_ADDRESS:     sect_addr   = data;
        REG_SECTION_FILE_OFFSET: sect_offset = data;
        REG_TARGET_ADDRESS:      target_addr = data;
        default: ;
      endcase
    endfunction

    // one accepted byte: scan the window, then shift it in
    function void note_byte(in_item_t item);
      logic [AddrWidth-1:0] pos, field_addr, disp;
      logic [31:0]          raw;
      out_item_t            want;
      bit                   found;
      int                   k;
      bytes_seen++;
      found = 1'b0;
      if (position >= (WindowBytes - 1) && (window[0] & ModrmMask) == ModrmRiprel) begin
        pos        = 64'(position) - 64'(WindowBytes - 1);
        raw        = {item.code_byte, window[3], window[2], window[1]};
        disp       = {{32{raw[31]}}, raw};
        field_addr = sect_addr + pos + 64'd1;
        for (k = 0; k < 4; k++) begin
          if (!found && field_addr + 64'd4 + 64'(ImmLengths[k]) + disp == target_addr) begin
            found = 1'b1;
            if (match_total != '1) match_total++;
            want.ref_address     = field_addr;
            want.ref_file_offset = sect_offset + pos + 64'd1;
            want.imm_length      = ImmLengths[k];
            want.match_count     = match_total;
            pending.push_back(want);
            expected_total++;
            len_hits[k]++;
          end
        end
      end
      window[0] = window[1];
      window[1] = window[2];
      window[2] = window[3];
      window[3] = item.code_byte;
      if (position != '1) position++;
      if (item.last_byte) begin
        clear_section();
        sections_seen++;
      end
    endfunction

    function void flag(string field, logic [AddrWidth-1:0] want, logic [AddrWidth-1:0] got);
      errors++;
      if (errors <= 10)
        $display("mismatch on match %0d: %s expected %h got %h", results_seen, field, want, got);
    endfunction

    function void check_match(out_item_t got);
      out_item_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected match: address %h offset %h imm %0d count %0d",
                   got.ref_address, got.ref_file_offset, got.imm_length, got.match_count);
      end else begin
        want = pending.pop_front();
        results_seen++;
        if (got.ref_address !== want.ref_address)
          flag("ref_address", want.ref_address, got.ref_address);
        if (got.ref_file_offset !== want.ref_file_offset)
          flag("ref_file_offset", want.ref_file_offset, got.ref_file_offset);
        if (got.imm_length !== want.imm_length)
          flag("imm_length", 64'(want.imm_length), 64'(got.imm_length));
        if (got.match_count !== want.match_count)
          flag("match_count", 64'(want.match_count), 64'(got.match_count));
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // clock, reset and block inputs, all known from time zero
  // --------------------------------------------------------------------------
  logic                 clk_i;
  logic                 rst_ni    = 1'b0;
  logic                 in_valid  = 1'b0;
  in_item_t             in_item   = '0;
  logic                 out_ready = 1'b0;
  logic                 cfg_we    = 1'b0;
  logic [1:0]           cfg_idx   = '0;
  logic [AddrWidth-1:0] cfg_wdata = '0;

  logic                 in_ready_o;
  logic                 out_valid_o;
  out_item_t            out_item_o;

  match_ledger ledger = new();

  // stimulus side copies of the settings, used to plant hits
  logic [AddrWidth-1:0] gen_addr   = '0;
  logic [AddrWidth-1:0] gen_target = '0;
  int unsigned          settings_loaded = 0;
  int unsigned          items_sent = 0;
  int unsigned          burst_left = 0;
  int                   quiet_cycles = 0;
  logic [7:0]           section_q [$];

  // receiver stall pattern
  logic [15:0]          stall_pattern = '1;
  int                   stall_age = 0;

  rip_relative_reference_scanner #(
    .POSITION_BITS(PositionBits)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_item_o  (out_item_o),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // single reset at the start of the run
  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // receiver: rotate a 16-bit ready pattern, reload it now and then;
  // bit 0 is always set on reload so every turn of the pattern brings ready back
  always @(posedge clk_i) begin
    if (stall_age == 0) begin
      case ($urandom_range(0, 3))
        0:       stall_pattern = '1;                                  // no stalls
        1:       stall_pattern = 16'($urandom) | 16'h0001;
        2:       stall_pattern = 16'h5555;                            // alternating ready and stall
        default: stall_pattern = (16'($urandom) & 16'($urandom)) | 16'h0001;  // heavy
      endcase
      stall_age = $urandom_range(16, 96);
    end
    stall_age--;
    out_ready <= stall_pattern[0];
    stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
  end

  // monitor: both channels sampled at the edge, before any update lands;
  // input noted first so a same-edge result would still find its entry
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && in_ready_o) ledger.note_byte(in_item);
      if (out_valid_o && out_ready) ledger.check_match(out_item_o);
      if ((in_valid && in_ready_o) || (out_valid_o && out_ready) || cfg_we)
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
  end

  // watchdog: nothing moved for too long
  initial begin
    wait (quiet_cycles >= QuietLimit);
    $display("watchdog: no transfer for %0d cycles, %0d matches outstanding",
             QuietLimit, ledger.pending.size());
    $display("rip_relative_reference_scanner regression: fail");
    $finish;
  end

  // --------------------------------------------------------------------------
  // driver tasks; each one is entered just after a rising edge
  // --------------------------------------------------------------------------

  // one byte transfer; bursts of random length with random gaps between
  task automatic push_byte(logic [7:0] code, logic last);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      // now and then a long stretch with no gaps at all
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 16);
    end
    burst_left--;
    in_valid          <= 1'b1;
    in_item.code_byte <= code;
    in_item.last_byte <= last;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
  endtask

  task automatic send_section();
    int n;
    for (n = 0; n < section_q.size(); n++)
      push_byte(section_q[n], n == section_q.size() - 1);
  endtask

  // stop sending and wait out every owed match plus the pipeline
  task automatic settle_block();
    in_valid <= 1'b0;
    while (ledger.pending.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // register write lands at the next edge; enable left high for the caller
  task automatic write_reg(logic [1:0] idx, logic [AddrWidth-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk_i);
    ledger.set_register(idx, data);
  endtask

  // only called while the block is idle
  task automatic load_registers(logic [AddrWidth-1:0] sa, logic [AddrWidth-1:0] fo,
                                logic [AddrWidth-1:0] tgt, bit stray_write);
    write_reg(REG_SECTION_ADDRESS, sa);
    write_reg(REG_SECTION_FILE_OFFSET, fo);
    write_reg(REG_TARGET_ADDRESS, tgt);
    // a write to the unused index must not disturb anything
    if (stray_write) write_reg(RegUnused, {$urandom, $urandom});
    cfg_we     <= 1'b0;
    gen_addr   = sa;
    gen_target = tgt;
    settings_loaded++;
  endtask

  task automatic random_setting();
    logic [AddrWidth-1:0] sa, tgt;
    logic [31:0]          r;
    sa = {$urandom, $urandom};
    r  = $urandom;
    case ($urandom_range(0, 7))
      0: tgt = {$urandom, $urandom};              // far target, hits only by chance
      1: begin
        sa  = ~64'(r[7:0]);                       // section straddles the top of memory
        tgt = sa + 64'h100;
      end
      default: tgt = sa + {{34{r[31]}}, r[29:0]}; // within reach of a disp32
    endcase
    load_registers(sa, {$urandom, $urandom}, tgt, $urandom_range(0, 2) == 0);
  endtask

  // random section with some operands aimed at the current target;
  // a planted disp32 only resolves when the target is in range
  function automatic void plan_section(int unsigned len, int unsigned refs);
    logic [AddrWidth-1:0] need;
    logic [31:0]          disp;
    logic [ImmWidth-1:0]  imm;
    int unsigned          p;
    int                   j;
    section_q.delete();
    repeat (len) section_q.push_back(8'($urandom));
    if (len >= WindowBytes) begin
      repeat (refs) begin
        p    = $urandom_range(0, len - WindowBytes);
        imm  = ImmLengths[$urandom_range(0, 3)];
        need = gen_target - (gen_addr + 64'(p) + 64'd5 + 64'(imm));
        disp = (need[63:31] == '0 || need[63:31] == '1) ? need[31:0] : $urandom;
        // mod=00 rm=101 with any reg field
        section_q[p] = ModrmRiprel | {2'b00, 3'($urandom_range(0, 7)), 3'b000};
        for (j = 0; j < 4; j++) section_q[p + 1 + j] = disp[8*j +: 8];
      end
    end
  endfunction

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    int unsigned sections_left;
    int unsigned kind;
    int unsigned random_until;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);

    // zero base and target; stray write to the unused index
    load_registers('0, '0, '0, 1'b1);
    // short section holding a would-be hit: too few bytes, no result
    section_q = '{8'h05, 8'hF8, 8'hFF, 8'hFF};
    send_section();
    // one-byte section
    section_q = '{8'hC5};
    send_section();
    // five bytes exactly, hit on the final byte with imm 1
    section_q = '{8'h05, 8'hFA, 8'hFF, 8'hFF, 8'hFF};
    send_section();
    // candidate one byte in, imm 2
    section_q = '{8'h90, 8'h05, 8'hF8, 8'hFF, 8'hFF, 8'hFF};
    send_section();

    // largest positive disp32, file offset wraps to zero
    settle_block();
    load_registers('0, '1, 64'd5 + 64'h7FFF_FFFF, 1'b0);
    section_q = '{8'h3D, 8'hFF, 8'hFF, 8'hFF, 8'h7F};
    send_section();

    // largest negative disp32 with imm 4, field address wraps past zero
    settle_block();
    load_registers('1, '0, 64'd8 - 64'h8000_0000, 1'b0);
    section_q = '{8'h05, 8'h00, 8'h00, 8'h00, 8'h80};
    send_section();

    // random sections: mostly planted operands, some short and some noise;
    // settings change between groups, each time after a full drain
    sections_left = 0;
    random_until  = items_sent + RandomItems;
    while (items_sent < random_until) begin
      if (sections_left == 0) begin
        settle_block();
        random_setting();
        sections_left = $urandom_range(2, 6);
      end
      sections_left--;
      kind = $urandom_range(0, 9);
      if (kind < 7)
        plan_section($urandom_range(5, 40), $urandom_range(1, 4));
      else if (kind < 8)
        plan_section($urandom_range(1, 4), 0);
      else
        plan_section($urandom_range(5, 32), 0);
      send_section();
    end

    settle_block();
    repeat (TailCycles) @(posedge clk_i);

    $display("run covered %0d bytes in %0d sections under %0d register settings",
             ledger.bytes_seen, ledger.sections_seen, settings_loaded);
    $display("%0d matches checked, by imm length 0/1/2/4: %0d/%0d/%0d/%0d",
             ledger.results_seen, ledger.len_hits[0], ledger.len_hits[1],
             ledger.len_hits[2], ledger.len_hits[3]);
    if (ledger.errors == 0 && ledger.pending.size() == 0) begin
      $display("rip_relative_reference_scanner regression: pass");
    end else begin
      $display("%0d mismatches, %0d matches never seen", ledger.errors, ledger.pending.size());
      $display("rip_relative_reference_scanner regression: fail");
    end
    $finish;
  end

endmodule
